>>> src/gram_schmidt_orthogonalize_3d_unit_macros.svh
// ---------------------------------------------------------------------------
// gso assertion macros
// concurrent check helpers, empty when synthesised
// ---------------------------------------------------------------------------
`ifndef GRAM_SCHMIDT_ORTHOGONALIZE_3D_UNIT_MACROS_SVH
`define GRAM_SCHMIDT_ORTHOGONALIZE_3D_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define GSO_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("gso assertion failed");
`define GSO_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("gso assertion failed");
`else
`define GSO_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define GSO_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

>>> src/gso_pkg.sv
// ---------------------------------------------------------------------------
// gso_pkg
// shared widths and unit interface types for the orthogonalisation block
// ---------------------------------------------------------------------------
package gso_pkg;
   localparam int DIVIDEND_W = 96;
   localparam int DIVISOR_W  = 64;
   localparam int DIV_CNT_W  = 7;
   localparam int RADICAND_W = 64;
   localparam int ROOT_W     = 32;

   typedef struct packed {
      logic                  start;
      logic [DIVIDEND_W-1:0] dividend;
      logic [DIVISOR_W-1:0]  divisor;
   } div_req_type;

   typedef struct packed {
      logic                  done;
      logic [DIVIDEND_W-1:0] quotient;
      logic [DIVISOR_W-1:0]  remainder;
   } div_rsp_type;

   typedef struct packed {
      logic                  start;
      logic [RADICAND_W-1:0] radicand;
   } sqrt_req_type;

   typedef struct packed {
      logic              done;
      logic [ROOT_W-1:0] root;
   } sqrt_rsp_type;
endpackage

>>> src/gso_divider.sv
// ---------------------------------------------------------------------------
// gso_divider
// restoring unsigned divider, one quotient bit per cycle
// ---------------------------------------------------------------------------
module gso_divider (
   input  logic                 clock,
   input  logic                 reset,
   input  gso_pkg::div_req_type req,
   output gso_pkg::div_rsp_type rsp
);
   logic [gso_pkg::DIVISOR_W-1:0]  rem_ff, rem_in;
   logic [gso_pkg::DIVIDEND_W-1:0] quo_ff, quo_in;
   logic [gso_pkg::DIVISOR_W-1:0]  den_ff, den_in;
   logic [gso_pkg::DIV_CNT_W-1:0]  cnt_ff, cnt_in;
   logic                           busy_ff, busy_in;
   logic                           done_ff, done_in;
   logic [gso_pkg::DIVISOR_W:0]    shifted;
   logic [gso_pkg::DIVISOR_W:0]    diff;
   logic                           ge;

   always_comb begin
      shifted = {rem_ff, quo_ff[gso_pkg::DIVIDEND_W-1]};
      diff    = shifted - {1'b0, den_ff};
      ge      = shifted >= {1'b0, den_ff};
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (req.start) begin
         rem_in  = '0;
         quo_in  = req.dividend;
         den_in  = req.divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = ge ? diff[gso_pkg::DIVISOR_W-1:0] : shifted[gso_pkg::DIVISOR_W-1:0];
         quo_in = {quo_ff[gso_pkg::DIVIDEND_W-2:0], ge};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == gso_pkg::DIV_CNT_W'(gso_pkg::DIVIDEND_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   assign rsp.done      = done_ff;
   assign rsp.quotient  = quo_ff;
   assign rsp.remainder = rem_ff;
endmodule

>>> src/gso_sqrt.sv
// ---------------------------------------------------------------------------
// gso_sqrt
// bit-pair integer square root, floor of the root, one pair per cycle
// ---------------------------------------------------------------------------
module gso_sqrt (
   input  logic                  clock,
   input  logic                  reset,
   input  gso_pkg::sqrt_req_type req,
   output gso_pkg::sqrt_rsp_type rsp
);
   logic [gso_pkg::RADICAND_W-1:0] x_ff, x_in;
   logic [gso_pkg::RADICAND_W-1:0] res_ff, res_in;
   logic [gso_pkg::RADICAND_W-1:0] bit_ff, bit_in;
   logic                           busy_ff, busy_in;
   logic                           done_ff, done_in;
   logic [gso_pkg::RADICAND_W:0]   trial;
   logic                           ge;

   always_comb begin
      trial   = {1'b0, res_ff} + {1'b0, bit_ff};
      ge      = {1'b0, x_ff} >= trial;
      x_in    = x_ff;
      res_in  = res_ff;
      bit_in  = bit_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (req.start) begin
         x_in    = req.radicand;
         res_in  = '0;
         bit_in  = {2'b01, {(gso_pkg::RADICAND_W-2){1'b0}}};
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (ge) begin
            x_in   = x_ff - trial[gso_pkg::RADICAND_W-1:0];
            res_in = (res_ff >> 1) + bit_ff;
         end else begin
            res_in = res_ff >> 1;
         end
         bit_in = bit_ff >> 2;
         if (bit_ff[0]) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff   <= x_in;
      res_ff <= res_in;
      bit_ff <= bit_in;
   end

   assign rsp.done = done_ff;
   assign rsp.root = res_ff[gso_pkg::ROOT_W-1:0];
endmodule

>>> src/gram_schmidt_orthogonalize_3d_unit.sv
// ---------------------------------------------------------------------------
// gram_schmidt_orthogonalize_3d_unit
// Takes one signed Q16.16 3D vector per transaction, removes its projection
// onto each stored basis vector, stores the residual while room remains and
// returns the residual, optionally scaled to unit length. One vector is in
// flight at a time. Each non-zero stored basis vector adds a projection pass,
// and normalising a non-zero residual adds a square root and three divisions;
// divisions use the bit-serial divider and the square root takes 32 steps.
// The result sits in an output register, so the next vector may be taken
// while it waits.
// ---------------------------------------------------------------------------
`include "gram_schmidt_orthogonalize_3d_unit_macros.svh"
module gram_schmidt_orthogonalize_3d_unit #(
   parameter int MAX_VECTORS = 3,
   parameter int FRAC_BITS   = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [31:0] req_vec_x,
   input  logic signed [31:0] req_vec_y,
   input  logic signed [31:0] req_vec_z,
   input  logic               req_start_set,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_out_x,
   output logic signed [31:0] rsp_out_y,
   output logic signed [31:0] rsp_out_z,
   output logic [1:0]         rsp_position_in_set,
   output logic               rsp_degenerate,
   output logic               rsp_store_full,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic               paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready
);
   localparam int KW = (MAX_VECTORS > 1) ? $clog2(MAX_VECTORS) : 1;
   localparam int RW = 44;
   localparam int CAP_W = 40;

   localparam logic [4:0] ST_IDLE    = 5'd0;
   localparam logic [4:0] ST_BASIS   = 5'd1;
   localparam logic [4:0] ST_DOT_MUL = 5'd2;
   localparam logic [4:0] ST_DOT_ACC = 5'd3;
   localparam logic [4:0] ST_DMAG    = 5'd4;
   localparam logic [4:0] ST_PM_LO   = 5'd5;
   localparam logic [4:0] ST_PM_HI   = 5'd6;
   localparam logic [4:0] ST_PM_ADD  = 5'd7;
   localparam logic [4:0] ST_PDIV_GO = 5'd8;
   localparam logic [4:0] ST_PDIV    = 5'd9;
   localparam logic [4:0] ST_SAT     = 5'd10;
   localparam logic [4:0] ST_LEN_MUL = 5'd11;
   localparam logic [4:0] ST_LEN_ACC = 5'd12;
   localparam logic [4:0] ST_DECIDE  = 5'd13;
   localparam logic [4:0] ST_SQRT    = 5'd14;
   localparam logic [4:0] ST_NDIV_GO = 5'd15;
   localparam logic [4:0] ST_NDIV    = 5'd16;
   localparam logic [4:0] ST_OUT     = 5'd17;

   logic [4:0]                       state_ff, state_in;
   logic [1:0]                       k_ff, k_in;
   logic [1:0]                       j_ff, j_in;
   logic signed [31:0]               v_ff [3];
   logic signed [31:0]               v_in [3];
   logic signed [RW-1:0]             r_ff [3];
   logic signed [RW-1:0]             r_in [3];
   logic signed [31:0]               rs_ff [3];
   logic signed [31:0]               rs_in [3];
   logic signed [31:0]               o_ff [3];
   logic signed [31:0]               o_in [3];
   logic [63:0]                      pos_sum_ff, pos_sum_in;
   logic [63:0]                      neg_sum_ff, neg_sum_in;
   logic [63:0]                      dmag_ff, dmag_in;
   logic                             dneg_ff, dneg_in;
   logic [63:0]                      prod_ff, prod_in;
   logic [gso_pkg::DIVIDEND_W-1:0]   nacc_ff, nacc_in;
   logic [63:0]                      len_ff, len_in;
   logic signed [31:0]               bx_ff [MAX_VECTORS];
   logic signed [31:0]               by_ff [MAX_VECTORS];
   logic signed [31:0]               bz_ff [MAX_VECTORS];
   logic [63:0]                      blen_ff [MAX_VECTORS];
   logic                             bwr;
   logic [1:0]                       count_ff, count_in;
   logic [1:0]                       setpos_ff, setpos_in;
   logic [1:0]                       pos_ff, pos_in;
   logic                             degen_ff, degen_in;
   logic                             full_ff, full_in;
   logic                             norm_ff, norm_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   logic                             rsp_load;
   logic signed [31:0]               u_cur;
   logic [31:0]                      mul_a, mul_b;
   logic [63:0]                      mul_p;
   logic [KW-1:0]                    kidx;
   logic [KW-1:0]                    widx;
   logic [CAP_W:0]                   qp;
   logic signed [RW-1:0]             qp_ext;
   logic [32:0]                      qn;
   logic                             pround, nround;
   logic [gso_pkg::DIVISOR_W-1:0]    root_ext;
   gso_pkg::div_req_type             div_req;
   gso_pkg::div_rsp_type             div_rsp;
   gso_pkg::sqrt_req_type            sqrt_req;
   gso_pkg::sqrt_rsp_type            sqrt_rsp;

   function automatic logic [31:0] magn32(input logic signed [31:0] a);
      magn32 = a[31] ? 32'(-a) : 32'(a);
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [RW-1:0] a);
      if (a > RW'(signed'(32'sh7fffffff))) begin
         sat32 = 32'sh7fffffff;
      end else if (a < $signed({{(RW-32){1'b1}}, 32'h80000000})) begin
         sat32 = 32'sh80000000;
      end else begin
         sat32 = a[31:0];
      end
   endfunction

   gso_divider u_div (
      .clock(clock),
      .reset(reset),
      .req  (div_req),
      .rsp  (div_rsp)
   );

   gso_sqrt u_sqrt (
      .clock(clock),
      .reset(reset),
      .req  (sqrt_req),
      .rsp  (sqrt_rsp)
   );

   assign kidx     = k_ff[KW-1:0];
   assign widx     = count_ff[KW-1:0];
   assign root_ext = {{(gso_pkg::DIVISOR_W-gso_pkg::ROOT_W){1'b0}}, sqrt_rsp.root};
   assign mul_p    = mul_a * mul_b;

   always_comb begin
      case (j_ff)
         2'd0:    u_cur = bx_ff[kidx];
         2'd1:    u_cur = by_ff[kidx];
         default: u_cur = bz_ff[kidx];
      endcase
   end

   always_comb begin
      case (state_ff)
         ST_DOT_MUL: begin
            mul_a = magn32(v_ff[j_ff]);
            mul_b = magn32(u_cur);
         end
         ST_PM_LO: begin
            mul_a = dmag_ff[31:0];
            mul_b = magn32(u_cur);
         end
         ST_PM_HI: begin
            mul_a = dmag_ff[63:32];
            mul_b = magn32(u_cur);
         end
         default: begin
            mul_a = magn32(rs_ff[j_ff]);
            mul_b = magn32(rs_ff[j_ff]);
         end
      endcase
   end

   // rounding and saturation of divider results
   always_comb begin
      pround = {div_rsp.remainder, 1'b0} >= {1'b0, blen_ff[kidx]};
      nround = {div_rsp.remainder, 1'b0} >= {1'b0, root_ext};
      if (div_rsp.quotient[gso_pkg::DIVIDEND_W-1:CAP_W] != '0) begin
         qp = {1'b1, {CAP_W{1'b0}}};
      end else begin
         qp = {1'b0, div_rsp.quotient[CAP_W-1:0]} + (CAP_W+1)'(pround);
      end
      qp_ext = RW'(qp);
      if (div_rsp.quotient[gso_pkg::DIVIDEND_W-1:32] != '0) begin
         qn = {1'b1, 32'd0};
      end else begin
         qn = {1'b0, div_rsp.quotient[31:0]} + 33'(nround);
      end
   end

   always_comb begin
      state_in     = state_ff;
      k_in         = k_ff;
      j_in         = j_ff;
      v_in         = v_ff;
      r_in         = r_ff;
      rs_in        = rs_ff;
      o_in         = o_ff;
      pos_sum_in   = pos_sum_ff;
      neg_sum_in   = neg_sum_ff;
      dmag_in      = dmag_ff;
      dneg_in      = dneg_ff;
      prod_in      = prod_ff;
      nacc_in      = nacc_ff;
      len_in       = len_ff;
      count_in     = count_ff;
      setpos_in    = setpos_ff;
      pos_in       = pos_ff;
      degen_in     = degen_ff;
      full_in      = full_ff;
      bwr          = 1'b0;
      rsp_load     = 1'b0;
      div_req.start    = 1'b0;
      div_req.dividend = nacc_ff;
      div_req.divisor  = blen_ff[kidx];
      sqrt_req.start    = 1'b0;
      sqrt_req.radicand = len_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               v_in[0] = req_vec_x;
               v_in[1] = req_vec_y;
               v_in[2] = req_vec_z;
               r_in[0] = RW'(req_vec_x);
               r_in[1] = RW'(req_vec_y);
               r_in[2] = RW'(req_vec_z);
               if (req_start_set) begin
                  count_in  = '0;
                  setpos_in = '0;
               end
               k_in     = '0;
               state_in = ST_BASIS;
            end
         end
         ST_BASIS: begin
            if (k_ff < count_ff) begin
               if (blen_ff[kidx] == '0) begin
                  k_in = k_ff + 1'b1;
               end else begin
                  pos_sum_in = '0;
                  neg_sum_in = '0;
                  j_in       = '0;
                  state_in   = ST_DOT_MUL;
               end
            end else begin
               state_in = ST_SAT;
            end
         end
         ST_DOT_MUL: begin
            prod_in  = mul_p;
            state_in = ST_DOT_ACC;
         end
         ST_DOT_ACC: begin
            if (v_ff[j_ff][31] ^ u_cur[31]) begin
               neg_sum_in = neg_sum_ff + prod_ff;
            end else begin
               pos_sum_in = pos_sum_ff + prod_ff;
            end
            if (j_ff == 2'd2) begin
               j_in     = '0;
               state_in = ST_DMAG;
            end else begin
               j_in     = j_ff + 1'b1;
               state_in = ST_DOT_MUL;
            end
         end
         ST_DMAG: begin
            dneg_in  = neg_sum_ff > pos_sum_ff;
            dmag_in  = (neg_sum_ff > pos_sum_ff) ? neg_sum_ff - pos_sum_ff
                                                 : pos_sum_ff - neg_sum_ff;
            state_in = ST_PM_LO;
         end
         ST_PM_LO: begin
            prod_in  = mul_p;
            state_in = ST_PM_HI;
         end
         ST_PM_HI: begin
            nacc_in  = gso_pkg::DIVIDEND_W'(prod_ff);
            prod_in  = mul_p;
            state_in = ST_PM_ADD;
         end
         ST_PM_ADD: begin
            nacc_in  = nacc_ff + {prod_ff, 32'd0};
            state_in = ST_PDIV_GO;
         end
         ST_PDIV_GO: begin
            div_req.start = 1'b1;
            state_in      = ST_PDIV;
         end
         ST_PDIV: begin
            if (div_rsp.done) begin
               if (dneg_ff ^ u_cur[31]) begin
                  r_in[j_ff] = r_ff[j_ff] + qp_ext;
               end else begin
                  r_in[j_ff] = r_ff[j_ff] - qp_ext;
               end
               if (j_ff == 2'd2) begin
                  j_in     = '0;
                  k_in     = k_ff + 1'b1;
                  state_in = ST_BASIS;
               end else begin
                  j_in     = j_ff + 1'b1;
                  state_in = ST_PM_LO;
               end
            end
         end
         ST_SAT: begin
            rs_in[0] = sat32(r_ff[0]);
            rs_in[1] = sat32(r_ff[1]);
            rs_in[2] = sat32(r_ff[2]);
            len_in   = '0;
            j_in     = '0;
            state_in = ST_LEN_MUL;
         end
         ST_LEN_MUL: begin
            prod_in  = mul_p;
            state_in = ST_LEN_ACC;
         end
         ST_LEN_ACC: begin
            len_in = len_ff + prod_ff;
            if (j_ff == 2'd2) begin
               j_in     = '0;
               state_in = ST_DECIDE;
            end else begin
               j_in     = j_ff + 1'b1;
               state_in = ST_LEN_MUL;
            end
         end
         ST_DECIDE: begin
            degen_in = len_ff == '0;
            full_in  = count_ff >= 2'(MAX_VECTORS);
            if (count_ff < 2'(MAX_VECTORS)) begin
               bwr      = 1'b1;
               count_in = count_ff + 1'b1;
            end
            pos_in = setpos_ff;
            if (setpos_ff != 2'd3) begin
               setpos_in = setpos_ff + 1'b1;
            end
            if (len_ff == '0) begin
               o_in[0] = '0;
               o_in[1] = '0;
               o_in[2] = '0;
               state_in = ST_OUT;
            end else if (norm_ff) begin
               sqrt_req.start = 1'b1;
               state_in       = ST_SQRT;
            end else begin
               o_in     = rs_ff;
               state_in = ST_OUT;
            end
         end
         ST_SQRT: begin
            if (sqrt_rsp.done) begin
               j_in     = '0;
               state_in = ST_NDIV_GO;
            end
         end
         ST_NDIV_GO: begin
            div_req.start    = 1'b1;
            div_req.dividend = gso_pkg::DIVIDEND_W'(magn32(rs_ff[j_ff])) << FRAC_BITS;
            div_req.divisor  = root_ext;
            state_in         = ST_NDIV;
         end
         ST_NDIV: begin
            if (div_rsp.done) begin
               if (rs_ff[j_ff][31]) begin
                  o_in[j_ff] = qn[32] | qn[31] ? 32'sh80000000 : 32'(-qn[31:0]);
               end else begin
                  o_in[j_ff] = qn[32] | qn[31] ? 32'sh7fffffff : 32'(qn[31:0]);
               end
               if (j_ff == 2'd2) begin
                  j_in     = '0;
                  state_in = ST_OUT;
               end else begin
                  j_in     = j_ff + 1'b1;
                  state_in = ST_NDIV_GO;
               end
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      norm_in = norm_ff;
      if (psel && penable && pwrite && (paddr == 1'b0)) begin
         norm_in = pwdata[0];
      end
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         setpos_ff    <= '0;
         norm_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         k_ff         <= '0;
         j_ff         <= '0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         setpos_ff    <= setpos_in;
         norm_ff      <= norm_in;
         rsp_valid_ff <= rsp_valid_in;
         k_ff         <= k_in;
         j_ff         <= j_in;
      end
   end

   always_ff @(posedge clock) begin
      v_ff       <= v_in;
      r_ff       <= r_in;
      rs_ff      <= rs_in;
      o_ff       <= o_in;
      pos_sum_ff <= pos_sum_in;
      neg_sum_ff <= neg_sum_in;
      dmag_ff    <= dmag_in;
      dneg_ff    <= dneg_in;
      prod_ff    <= prod_in;
      nacc_ff    <= nacc_in;
      len_ff     <= len_in;
      pos_ff     <= pos_in;
      degen_ff   <= degen_in;
      full_ff    <= full_in;
      if (bwr) begin
         bx_ff[widx]   <= rs_ff[0];
         by_ff[widx]   <= rs_ff[1];
         bz_ff[widx]   <= rs_ff[2];
         blen_ff[widx] <= len_ff;
      end
      if (rsp_load) begin
         rsp_out_x           <= o_ff[0];
         rsp_out_y           <= o_ff[1];
         rsp_out_z           <= o_ff[2];
         rsp_position_in_set <= pos_ff;
         rsp_degenerate      <= degen_ff;
         rsp_store_full      <= full_ff;
      end
   end

   assign req_ready = state_ff == ST_IDLE;
   assign rsp_valid = rsp_valid_ff;
   assign pready    = 1'b1;
   assign prdata    = (paddr == 1'b0) ? {31'd0, norm_ff} : 32'd0;

   `GSO_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && req_ready, !req_ready)
   `GSO_ASSERT_IMP(a_count_bound, clock, reset, 1'b1, count_ff <= 2'(MAX_VECTORS))
   `GSO_ASSERT_IMP(a_degen_zero, clock, reset, rsp_valid && rsp_degenerate, rsp_out_x == 0 && rsp_out_y == 0 && rsp_out_z == 0)
   `GSO_ASSERT_IMP(a_full_position, clock, reset, rsp_valid && rsp_store_full, rsp_position_in_set != 2'd0)
endmodule
